// ----- src/tkr_pkg.sv -----
`default_nettype none

package tkr_pkg;

   localparam int unsigned OptBase  = 20;
   localparam int unsigned PosMax   = 127;
   localparam int unsigned PosBits  = 7;
   localparam int unsigned HlenBits = 6;

   localparam logic [7:0] MATCH_KIND_RST   = 8'd8;
   localparam logic [7:0] REPLACE_KIND_RST = 8'd253;

   // register indexes on the csr port
   typedef enum logic [0:0] {
      CSR_MATCH_KIND   = 1'b0,
      CSR_REPLACE_KIND = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
      logic       is_fragment;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_summary;
      logic        verdict;
      logic [15:0] new_checksum;
      logic        run_last;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/tcp_option_kind_rewriter_unit.sv -----
`default_nettype none

// channel  | handshake             | payload
// ---------+-----------------------+--------------------------
// request  | req_valid / req_ready | req_data  (tkr_pkg::req_type)
// response | rsp_valid / rsp_ready | rsp_data  (tkr_pkg::rsp_type)
// csr      | csr_we                | csr_index, csr_wdata
//
// A word is held in an input register, its results are formed there and move
// one per cycle, unless rsp_ready stalls, into the response register. The next
// word is taken as a word finishes, so a plain mid-segment stream runs at one
// word a cycle while nothing stalls; a last word has two results (own byte,
// summary), three when a byte is held. Segment state is committed as the final
// result of a word leaves the input register.
// Synchronous reset clears control and segment state; csr returns to defaults.
// A stall on rsp_ready holds the response register and any word in the input
// register that still has a result to send.

module tcp_option_kind_rewriter_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire tkr_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      tkr_pkg::rsp_type rsp_data,
   input  wire logic             csr_we,
   input  wire logic [0:0]       csr_index,
   input  wire logic [7:0]       csr_wdata
);

   localparam logic [6:0] OPT_BASE = 7'(tkr_pkg::OptBase);
   localparam logic [6:0] POS_MAX  = 7'(tkr_pkg::PosMax);

   localparam logic [7:0] MATCH_KIND_RST_V   = tkr_pkg::MATCH_KIND_RST;
   localparam logic [7:0] REPLACE_KIND_RST_V = tkr_pkg::REPLACE_KIND_RST;

   function automatic logic [15:0] ones_replace(input logic [15:0] hc,
                                                input logic [15:0] m,
                                                input logic [15:0] m2);
      logic [17:0] s;
      logic [16:0] s1;
      logic [15:0] s2;
      s  = {2'b00, ~hc} + {2'b00, ~m} + {2'b00, m2};
      s1 = {1'b0, s[15:0]} + {15'd0, s[17:16]};
      s2 = s1[15:0] + {15'd0, s1[16]};
      return ~s2;
   endfunction

   // csr
   logic [7:0] match_kind_ff, replace_kind_ff;

   // input stage
   logic             in_valid_ff, in_valid_in;
   tkr_pkg::req_type in_ff;
   logic             sent_held_ff, sent_held_in;
   logic             sent_byte_ff, sent_byte_in;

   // segment state
   logic [6:0]  pos_ff, pos_in;
   logic [5:0]  hlen_ff, hlen_in;
   logic [6:0]  nos_ff, nos_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_valid_ff, held_valid_in;
   logic        walk_stop_ff, walk_stop_in;
   logic [15:0] csum_ff, csum_in;
   logic        frag_ff, frag_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   tkr_pkg::rsp_type rsp_ff, rsp_in;

   // working signals
   logic        first, last;
   logic [6:0]  pos_eff, nos_eff, p;
   logic [5:0]  hlen_eff, hlen_upd;
   logic [15:0] csum_eff, csum_upd, csum_new;
   logic        walk_eff, frag_eff, emit_held, walk_on, walk_new;
   logic [7:0]  optl, held_new;
   logic [8:0]  opt_end;
   logic [6:0]  nos_new;
   logic [15:0] m, m2;
   logic [7:0]  seg_len;
   logic        drop;
   logic        cur_held, cur_byte, no_out, is_final, out_free, advance;
   tkr_pkg::rsp_type result;

   always_comb begin
      first    = in_ff.first_byte;
      last     = in_ff.last_byte;
      pos_eff  = first ? '0 : pos_ff;
      hlen_eff = first ? '0 : hlen_ff;
      nos_eff  = first ? OPT_BASE : nos_ff;
      walk_eff = first ? 1'b0 : walk_stop_ff;
      csum_eff = first ? '0 : csum_ff;
      frag_eff = (pos_eff == '0) ? in_ff.is_fragment : frag_ff;

      // pick up data offset and checksum from the header
      hlen_upd = hlen_eff;
      csum_upd = csum_eff;
      if (!frag_eff) begin
         if (pos_eff == 7'd12) begin
            hlen_upd = {in_ff.data_byte[7:4], 2'b00};
         end else if (pos_eff == 7'd16) begin
            csum_upd = {in_ff.data_byte, 8'h00};
         end else if (pos_eff == 7'd17) begin
            csum_upd = {csum_eff[15:8], in_ff.data_byte};
         end
      end

      // option walk on the held byte, with this word as its length byte
      emit_held = !first && held_valid_ff;
      p         = pos_eff - 7'd1;
      walk_on   = emit_held && (pos_eff != '0) && (pos_eff != POS_MAX) && !frag_eff &&
                  !walk_eff && (p >= OPT_BASE) && (p == nos_eff) &&
                  (({1'b0, p} + 8'd1) < {2'b00, hlen_upd});
      optl      = ((held_byte_ff <= 8'd1) || (in_ff.data_byte == 8'd0)) ? 8'd1
                                                                       : in_ff.data_byte;
      opt_end   = {2'b00, p} + {1'b0, optl};
      m         = p[0] ? {8'h00, held_byte_ff} : {held_byte_ff, 8'h00};
      m2        = p[0] ? {8'h00, replace_kind_ff} : {replace_kind_ff, 8'h00};

      walk_new = walk_eff;
      csum_new = csum_upd;
      held_new = held_byte_ff;
      nos_new  = nos_eff;
      if (walk_on) begin
         if (opt_end > {3'b000, hlen_upd}) begin
            walk_new = 1'b1;
         end else begin
            if (held_byte_ff == match_kind_ff) begin
               csum_new = ones_replace(csum_upd, m, m2);
               held_new = replace_kind_ff;
            end
            nos_new = opt_end[6:0];
         end
      end

      seg_len = {1'b0, pos_eff} + 8'd1;
      drop    = !frag_eff && ((seg_len < 8'(tkr_pkg::OptBase)) ||
                              (seg_len < {2'b00, hlen_upd}));

      // result sequencing: held byte, own byte, summary
      cur_held = held_valid_ff && !sent_held_ff;
      cur_byte = !cur_held && last && !sent_byte_ff;
      no_out   = !held_valid_ff && !last;
      is_final = no_out || (!cur_held && !cur_byte) || (cur_held && !last);
      out_free = !rsp_valid_ff || rsp_ready;
      advance  = in_valid_ff && (no_out || out_free);
      req_ready = !in_valid_ff || (is_final && (no_out || out_free));

      result = '0;
      result.run_last = is_final;
      if (cur_held) begin
         result.out_byte = held_new;
      end else if (cur_byte) begin
         result.out_byte = in_ff.data_byte;
      end else begin
         result.is_summary   = 1'b1;
         result.verdict      = drop;
         result.new_checksum = (frag_eff || drop) ? '0 : csum_new;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = in_valid_ff && !no_out;
         rsp_in       = result;
      end

      in_valid_in  = in_valid_ff;
      sent_held_in = sent_held_ff;
      sent_byte_in = sent_byte_ff;
      if (advance) begin
         if (is_final) begin
            in_valid_in  = 1'b0;
            sent_held_in = 1'b0;
            sent_byte_in = 1'b0;
         end else if (cur_held) begin
            sent_held_in = 1'b1;
         end else begin
            sent_byte_in = 1'b1;
         end
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end

      // commit segment state with the final result of the word
      pos_in        = pos_ff;
      hlen_in       = hlen_ff;
      nos_in        = nos_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      walk_stop_in  = walk_stop_ff;
      csum_in       = csum_ff;
      frag_in       = frag_ff;
      if (advance && is_final) begin
         if (last) begin
            pos_in        = '0;
            hlen_in       = '0;
            nos_in        = OPT_BASE;
            held_byte_in  = '0;
            held_valid_in = 1'b0;
            walk_stop_in  = 1'b0;
            csum_in       = '0;
            frag_in       = 1'b0;
         end else begin
            pos_in        = (pos_eff < POS_MAX) ? pos_eff + 7'd1 : pos_eff;
            hlen_in       = hlen_upd;
            nos_in        = nos_new;
            held_byte_in  = in_ff.data_byte;
            held_valid_in = 1'b1;
            walk_stop_in  = walk_new;
            csum_in       = csum_new;
            frag_in       = frag_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_kind_ff   <= MATCH_KIND_RST_V;
         replace_kind_ff <= REPLACE_KIND_RST_V;
         in_valid_ff     <= 1'b0;
         sent_held_ff    <= 1'b0;
         sent_byte_ff    <= 1'b0;
         pos_ff          <= '0;
         hlen_ff         <= '0;
         nos_ff          <= OPT_BASE;
         held_byte_ff    <= '0;
         held_valid_ff   <= 1'b0;
         walk_stop_ff    <= 1'b0;
         csum_ff         <= '0;
         frag_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (tkr_pkg::csr_index_type'(csr_index))
               tkr_pkg::CSR_MATCH_KIND:   match_kind_ff   <= csr_wdata;
               tkr_pkg::CSR_REPLACE_KIND: replace_kind_ff <= csr_wdata;
               default: ;
            endcase
         end
         in_valid_ff   <= in_valid_in;
         sent_held_ff  <= sent_held_in;
         sent_byte_ff  <= sent_byte_in;
         pos_ff        <= pos_in;
         hlen_ff       <= hlen_in;
         nos_ff        <= nos_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         walk_stop_ff  <= walk_stop_in;
         csum_ff       <= csum_in;
         frag_ff       <= frag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- dv/tcp_option_kind_rewriter_unit_tb.sv -----
`timescale 1ns / 1ps

module tcp_option_kind_rewriter_unit_tb;

   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 200000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   tkr_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   tkr_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic    [0:0]    csr_index = tkr_pkg::CSR_MATCH_KIND;
   logic    [7:0]    csr_wdata = '0;

   tcp_option_kind_rewriter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor state
   logic [7:0]  match_kind_q   = tkr_pkg::MATCH_KIND_RST;
   logic [7:0]  replace_kind_q = tkr_pkg::REPLACE_KIND_RST;
   logic [6:0]  seg_pos        = '0;
   logic [5:0]  hdr_len        = '0;
   logic [6:0]  opt_next       = 7'(tkr_pkg::OptBase);
   logic [7:0]  held           = '0;
   bit          held_v         = 1'b0;
   bit          walk_halt      = 1'b0;
   logic [15:0] csum           = '0;
   bit          frag_mode      = 1'b0;

   tkr_pkg::rsp_type rewritten_q[$];
   logic [7:0]       seg_bytes[$];

   int               mismatch_count = 0;
   int               cycle_count    = 0;
   int               req_idle_pct   = 0;
   int               rsp_stall_pct  = 0;
   int               rsp_hold_left  = 0;
   tkr_pkg::rsp_type exp_word;

   function automatic void clear_segment();
      seg_pos   = '0;
      hdr_len   = '0;
      opt_next  = 7'(tkr_pkg::OptBase);
      held      = '0;
      held_v    = 1'b0;
      walk_halt = 1'b0;
      csum      = '0;
      frag_mode = 1'b0;
   endfunction

   function automatic logic [15:0] ones_swap(logic [15:0] hc, logic [15:0] old_w,
                                             logic [15:0] new_w);
      logic [17:0] s;
      s = {2'b00, ~hc} + {2'b00, ~old_w} + {2'b00, new_w};
      s = {2'b00, s[15:0]} + {16'h0000, s[17:16]};
      s = {2'b00, s[15:0]} + {16'h0000, s[17:16]};
      return ~s[15:0];
   endfunction

   function automatic tkr_pkg::rsp_type byte_result(logic [7:0] b);
      tkr_pkg::rsp_type r;
      r = '0;
      r.out_byte = b;
      return r;
   endfunction

   // settle the held option kind at offset p, nxt being the byte after it
   function automatic void option_decide(int p, logic [7:0] nxt);
      int          optl;
      logic [15:0] old_w;
      logic [15:0] new_w;
      if (frag_mode || walk_halt || p < int'(tkr_pkg::OptBase) || p != int'(opt_next))
         return;
      if (hdr_len < 1 || p >= int'(hdr_len) - 1) return;
      optl = (held <= 8'd1 || nxt == 8'd0) ? 1 : int'(nxt);
      if (p + optl > int'(hdr_len)) begin
         walk_halt = 1'b1;
         return;
      end
      if (held == match_kind_q) begin
         if (p % 2 == 0) begin
            old_w = {held, 8'h00};
            new_w = {replace_kind_q, 8'h00};
         end else begin
            old_w = {8'h00, held};
            new_w = {8'h00, replace_kind_q};
         end
         csum = ones_swap(csum, old_w, new_w);
         held = replace_kind_q;
      end
      opt_next = 7'(p + optl);
   endfunction

   function automatic void rewrite_word(tkr_pkg::req_type w);
      tkr_pkg::rsp_type res[3];
      int               n;
      int               pos;
      n = 0;
      if (w.first_byte) begin
         if (held_v) begin
            res[n] = byte_result(held);
            n++;
         end
         clear_segment();
      end
      pos = int'(seg_pos);
      if (pos == 0) frag_mode = w.is_fragment;
      if (!frag_mode) begin
         if (pos == 12) hdr_len = {w.data_byte[7:4], 2'b00};
         else if (pos == 16) csum = {w.data_byte, 8'h00};
         else if (pos == 17) csum[7:0] = w.data_byte;
      end
      if (held_v) begin
         if (pos > 0 && pos < int'(tkr_pkg::PosMax)) option_decide(pos - 1, w.data_byte);
         res[n] = byte_result(held);
         n++;
         held_v = 1'b0;
      end
      if (w.last_byte) begin
         res[n] = byte_result(w.data_byte);
         n++;
         res[n] = '0;
         res[n].is_summary = 1'b1;
         if (!frag_mode) begin
            if (pos + 1 < int'(tkr_pkg::OptBase) || pos + 1 < int'(hdr_len))
               res[n].verdict = 1'b1;
            else res[n].new_checksum = csum;
         end
         n++;
         clear_segment();
      end else begin
         held   = w.data_byte;
         held_v = 1'b1;
         if (seg_pos < 7'(tkr_pkg::PosMax)) seg_pos++;
      end
      if (n > 0) res[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) rewritten_q.push_back(res[i]);
   endfunction

   function automatic void note_mismatch(string what, tkr_pkg::rsp_type exp,
                                         tkr_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: exp byte %h sum %b drop %b csum %h last %b / got %h %b %b %h %b",
                  $time, what, exp.out_byte, exp.is_summary, exp.verdict, exp.new_checksum,
                  exp.run_last, got.out_byte, got.is_summary, got.verdict, got.new_checksum,
                  got.run_last);
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (rewritten_q.size() == 0) begin
            note_mismatch("unexpected word", '0, rsp_data);
         end else begin
            exp_word = rewritten_q.pop_front();
            if (rsp_data.out_byte !== exp_word.out_byte ||
                rsp_data.is_summary !== exp_word.is_summary ||
                rsp_data.verdict !== exp_word.verdict ||
                rsp_data.new_checksum !== exp_word.new_checksum ||
                rsp_data.run_last !== exp_word.run_last)
               note_mismatch("word mismatch", exp_word, rsp_data);
         end
      end
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_word(input tkr_pkg::req_type w);
      int gap;
      gap = ($urandom_range(99) < req_idle_pct) ? int'($urandom_range(1, 3)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      rewrite_word(w);
   endtask

   task automatic send_bytes(input bit frag, input bit mark_first);
      tkr_pkg::req_type w;
      for (int i = 0; i < seg_bytes.size(); i++) begin
         w.data_byte   = seg_bytes[i];
         w.first_byte  = (i == 0) ? mark_first : 1'b0;
         w.last_byte   = (i == seg_bytes.size() - 1);
         w.is_fragment = (i == 0) ? frag : 1'($urandom_range(1));
         send_word(w);
      end
   endtask

   // drop valid and hold until every expected word is back
   task automatic await_idle();
      req_valid <= 1'b0;
      while (rewritten_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [7:0] match_val, input logic [7:0] replace_val);
      csr_we    <= 1'b1;
      csr_index <= tkr_pkg::CSR_MATCH_KIND;
      csr_wdata <= match_val;
      @(posedge clock);
      csr_index <= tkr_pkg::CSR_REPLACE_KIND;
      csr_wdata <= replace_val;
      @(posedge clock);
      csr_we <= 1'b0;
      match_kind_q   = match_val;
      replace_kind_q = replace_val;
   endtask

   task automatic build_tcp_segment(input int doff, input int payload_len, input bit cut);
      int         hl;
      int         idx;
      int         r;
      int         olen;
      int         keep;
      logic [7:0] kind;
      logic [3:0] nib;
      seg_bytes = {};
      for (int i = 0; i < 20; i++) seg_bytes.push_back(8'($urandom_range(255)));
      nib = 4'($urandom_range(15));
      seg_bytes[12] = {4'(doff), nib};
      hl  = doff * 4;
      idx = 20;
      while (idx < hl) begin
         r = $urandom_range(99);
         kind = (r < 35) ? match_kind_q : (r < 50) ? 8'd1 : (r < 55) ? 8'd0 :
                8'($urandom_range(255));
         seg_bytes.push_back(kind);
         idx++;
         if (kind > 8'd1 && idx < hl) begin
            r = $urandom_range(99);
            if (r < 8) olen = 0;
            else if (r < 16) olen = $urandom_range(255);
            else olen = $urandom_range(2, (hl - idx + 1 < 10) ? hl - idx + 1 : 10);
            seg_bytes.push_back(8'(olen));
            idx++;
            for (int k = 2; k < olen && idx < hl; k++) begin
               seg_bytes.push_back(8'($urandom_range(255)));
               idx++;
            end
         end
      end
      repeat (payload_len) seg_bytes.push_back(8'($urandom_range(255)));
      if (cut) begin
         keep = $urandom_range(1, seg_bytes.size());
         while (seg_bytes.size() > keep) void'(seg_bytes.pop_back());
      end
   endtask

   task automatic random_segment();
      int r;
      int doff;
      r = $urandom_range(99);
      if (r < 10) doff = $urandom_range(0, 4);
      else if (r < 85) doff = $urandom_range(5, 10);
      else doff = $urandom_range(11, 15);
      build_tcp_segment(doff, $urandom_range(0, 6), $urandom_range(99) < 15);
      send_bytes($urandom_range(99) < 10, $urandom_range(99) < 90);
   endtask

   task automatic test_short_segments();
      seg_bytes = {8'hFF};
      send_bytes(1'b0, 1'b1);
      seg_bytes = {8'h00, 8'h80, 8'h7F};
      send_bytes(1'b0, 1'b1);
      await_idle();
   endtask

   task automatic test_fragment_passthrough();
      seg_bytes = {8'h08, 8'h0A, 8'hF0, 8'h08, 8'h55};
      send_bytes(1'b1, 1'b1);
      await_idle();
   endtask

   task automatic test_segment_restart();
      tkr_pkg::req_type w;
      // open a segment and abandon it: the held byte is flushed by the next first mark
      seg_bytes = {8'h45, 8'h01, 8'hAA};
      foreach (seg_bytes[i]) begin
         w.data_byte   = seg_bytes[i];
         w.first_byte  = (i == 0);
         w.last_byte   = 1'b0;
         w.is_fragment = 1'b0;
         send_word(w);
      end
      seg_bytes = {8'hFE, 8'h01};
      send_bytes(1'b0, 1'b1);
      // next segment starts without its first mark
      seg_bytes = {8'h10, 8'h20, 8'h30};
      send_bytes(1'b0, 1'b0);
      await_idle();
   endtask

   task automatic test_option_walk();
      logic [7:0] kinds[4];
      kinds = '{8'd2, 8'd3, 8'd4, 8'd30};
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0; end
            1: begin
               req_idle_pct = 67; rsp_stall_pct = 0;
               write_config(8'd0, 8'd255);
            end
            2: begin
               req_idle_pct = 0;  rsp_stall_pct = 67;
               write_config(8'd255, 8'd0);
            end
            default: begin
               req_idle_pct = 34; rsp_stall_pct = 34;
               write_config(kinds[$urandom_range(3)], 8'($urandom_range(255)));
            end
         endcase
         repeat (2) random_segment();
         await_idle();
      end
   endtask

   task automatic test_overlong_segment();
      build_tcp_segment(15, 72, 1'b0);
      send_bytes(1'b0, 1'b1);
      await_idle();
   endtask

   task automatic test_backpressure();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      write_config(8'd1, tkr_pkg::REPLACE_KIND_RST);
      // hold the receiver off while the sender keeps offering
      rsp_hold_left = 300;
      build_tcp_segment(8, 12, 1'b0);
      send_bytes(1'b0, 1'b1);
      await_idle();
      write_config(tkr_pkg::MATCH_KIND_RST, tkr_pkg::REPLACE_KIND_RST);
   endtask

   task automatic test_noise();
      tkr_pkg::req_type w;
      req_idle_pct  = 34;
      rsp_stall_pct = 34;
      repeat (30) begin
         w.data_byte   = 8'($urandom_range(255));
         w.first_byte  = ($urandom_range(99) < 20);
         w.last_byte   = ($urandom_range(99) < 15);
         w.is_fragment = 1'($urandom_range(1));
         send_word(w);
      end
      random_segment();
      await_idle();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_short_segments();
      test_fragment_passthrough();
      test_segment_restart();
      test_option_walk();
      test_overlong_segment();
      test_backpressure();
      test_noise();
      await_idle();
      if (mismatch_count == 0 && rewritten_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- tcp_option_kind_rewriter_unit.f -----
src/tkr_pkg.sv
src/tcp_option_kind_rewriter_unit.sv
dv/tcp_option_kind_rewriter_unit_tb.sv
